[rtl/ufcm_pkg.sv]
package ufcm_pkg;

	localparam int NODE_W = 10;
	localparam int CNT_W = 11;
	localparam int EDGE_W = 16;
	localparam int CFG_W = 11;
	localparam int CFG_IDX_W = 1;

	localparam int DEF_MAX_VERTICES = 1024;
	localparam int DEF_WEIGHT_BITS = 16;

	localparam logic [CNT_W-1:0] VERTEX_COUNT_RST = 11'd1024;
	localparam logic [CNT_W-1:0] CLUSTER_TARGET_RST = 11'd1;

	typedef enum logic [1:0] {
		ST_MERGED  = 2'd0,
		ST_SAME    = 2'd1,
		ST_IGNORED = 2'd2,
		ST_RANGE   = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_VERTEX_COUNT   = 1'b0,
		REG_CLUSTER_TARGET = 1'b1
	} cfg_reg_t;

endpackage

[rtl/ufcm_mem.sv]
module ufcm_mem #(
	parameter int MAX_VERTICES = ufcm_pkg::DEF_MAX_VERTICES,
	parameter int WEIGHT_BITS = ufcm_pkg::DEF_WEIGHT_BITS
) (
	input  logic                            clk,
	input  logic [$clog2(MAX_VERTICES)-1:0] rd_addr,
	output logic [$clog2(MAX_VERTICES)-1:0] rd_data,
	input  logic                            pw_en,
	input  logic [$clog2(MAX_VERTICES)-1:0] pw_addr,
	input  logic [$clog2(MAX_VERTICES)-1:0] pw_data,
	input  logic                            ww_en,
	input  logic [$clog2(MAX_VERTICES)-1:0] ww_addr,
	input  logic [WEIGHT_BITS-1:0]          ww_data
);
	import ufcm_pkg::*;

	localparam int IW = $clog2(MAX_VERTICES);

	logic [IW-1:0]          parent_mem [MAX_VERTICES];
	logic [WEIGHT_BITS-1:0] weight_mem [MAX_VERTICES];
	logic [IW-1:0]          rd_q;

	always_ff @(posedge clk) begin
		if (pw_en) begin
			parent_mem[pw_addr] <= pw_data;
		end
		rd_q <= parent_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (ww_en) begin
			weight_mem[ww_addr] <= ww_data;
		end
	end

	assign rd_data = rd_q;

endmodule

[rtl/ufcm_seq.sv]
module ufcm_seq #(
	parameter int MAX_VERTICES = ufcm_pkg::DEF_MAX_VERTICES,
	parameter int WEIGHT_BITS = ufcm_pkg::DEF_WEIGHT_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [ufcm_pkg::NODE_W-1:0]     node_a,
	input  logic [ufcm_pkg::NODE_W-1:0]     node_b,
	input  logic [ufcm_pkg::EDGE_W-1:0]     edge_weight,
	input  logic [ufcm_pkg::CNT_W-1:0]      vtx_n,
	input  logic [ufcm_pkg::CNT_W-1:0]      merge_lim,
	output logic                            done,
	output ufcm_pkg::status_t               status,
	output logic [ufcm_pkg::NODE_W-1:0]     new_root,
	output logic [ufcm_pkg::CNT_W-1:0]      merges_done,
	output logic                            target_reached,
	output logic [$clog2(MAX_VERTICES)-1:0] rd_addr,
	input  logic [$clog2(MAX_VERTICES)-1:0] rd_data,
	output logic                            pw_en,
	output logic [$clog2(MAX_VERTICES)-1:0] pw_addr,
	output logic [$clog2(MAX_VERTICES)-1:0] pw_data,
	output logic                            ww_en,
	output logic [$clog2(MAX_VERTICES)-1:0] ww_addr,
	output logic [WEIGHT_BITS-1:0]          ww_data
);
	import ufcm_pkg::*;

	localparam int IW = $clog2(MAX_VERTICES);
	localparam logic [IW-1:0] LAST_IDX = IW'(MAX_VERTICES - 1);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_RD,
		S_FIND,
		S_FIX_RD,
		S_FIX,
		S_MERGE
	} state_t;

	state_t                 state_q;
	logic [IW-1:0]          clr_q;
	logic [IW-1:0]          b_q;
	logic [WEIGHT_BITS-1:0] w_q;
	logic [IW-1:0]          cur_q;
	logic [IW-1:0]          org_q;
	logic [IW-1:0]          root_q;
	logic [IW-1:0]          ra_q;
	logic                   sel_q;
	logic                   ro_q;
	logic [CNT_W-1:0]       total_q;
	logic                   done_q;
	status_t                status_q;
	logic [NODE_W-1:0]      newroot_q;
	logic                   target_q;

	logic                   in_range;
	logic                   reached_now;
	logic [CNT_W-1:0]       total_inc;

	assign in_range = (CNT_W'(node_a) < vtx_n) && (CNT_W'(node_b) < vtx_n);
	assign reached_now = total_q >= merge_lim;
	assign total_inc = total_q + 1'b1;

	always_comb begin
		rd_addr = cur_q;
		pw_en = 1'b0;
		pw_addr = cur_q;
		pw_data = root_q;
		ww_en = 1'b0;
		ww_addr = root_q;
		ww_data = w_q;
		unique case (state_q)
			S_CLEAR: begin
				pw_en = 1'b1;
				pw_addr = clr_q;
				pw_data = clr_q;
				ww_en = 1'b1;
				ww_addr = clr_q;
				ww_data = '0;
			end
			S_FIND: begin
				rd_addr = rd_data;
			end
			S_FIX: begin
				rd_addr = rd_data;
				pw_en = 1'b1;
			end
			S_MERGE: begin
				pw_en = (ra_q != root_q);
				pw_addr = ra_q;
				ww_en = (ra_q != root_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			b_q <= '0;
			w_q <= '0;
			cur_q <= '0;
			org_q <= '0;
			root_q <= '0;
			ra_q <= '0;
			sel_q <= 1'b0;
			ro_q <= 1'b0;
			total_q <= '0;
			done_q <= 1'b0;
			status_q <= ST_MERGED;
			newroot_q <= '0;
			target_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_IDX) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						b_q <= IW'(node_b);
						w_q <= WEIGHT_BITS'(edge_weight);
						if (!in_range) begin
							done_q <= 1'b1;
							status_q <= ST_RANGE;
							newroot_q <= '0;
							target_q <= reached_now;
						end else if (reached_now) begin
							cur_q <= IW'(node_b);
							org_q <= IW'(node_b);
							ro_q <= 1'b1;
							sel_q <= 1'b1;
							state_q <= S_RD;
						end else begin
							cur_q <= IW'(node_a);
							org_q <= IW'(node_a);
							ro_q <= 1'b0;
							sel_q <= 1'b0;
							state_q <= S_RD;
						end
					end
				end
				S_RD: begin
					state_q <= S_FIND;
				end
				S_FIND: begin
					if (rd_data == cur_q) begin
						root_q <= cur_q;
						if (ro_q) begin
							done_q <= 1'b1;
							status_q <= ST_IGNORED;
							newroot_q <= NODE_W'(cur_q);
							target_q <= reached_now;
							state_q <= S_IDLE;
						end else if (org_q != cur_q) begin
							cur_q <= org_q;
							state_q <= S_FIX_RD;
						end else if (!sel_q) begin
							ra_q <= cur_q;
							sel_q <= 1'b1;
							cur_q <= b_q;
							org_q <= b_q;
							state_q <= S_RD;
						end else begin
							state_q <= S_MERGE;
						end
					end else begin
						cur_q <= rd_data;
					end
				end
				S_FIX_RD: begin
					state_q <= S_FIX;
				end
				S_FIX: begin
					if (rd_data == root_q) begin
						if (!sel_q) begin
							ra_q <= root_q;
							sel_q <= 1'b1;
							cur_q <= b_q;
							org_q <= b_q;
							state_q <= S_RD;
						end else begin
							state_q <= S_MERGE;
						end
					end else begin
						cur_q <= rd_data;
					end
				end
				S_MERGE: begin
					done_q <= 1'b1;
					newroot_q <= NODE_W'(root_q);
					if (ra_q == root_q) begin
						status_q <= ST_SAME;
						target_q <= reached_now;
					end else begin
						status_q <= ST_MERGED;
						total_q <= total_inc;
						target_q <= total_inc >= merge_lim;
					end
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign status = status_q;
	assign new_root = newroot_q;
	assign merges_done = total_q;
	assign target_reached = target_q;

	a_total_on_merge: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(total_q) |-> (done_q && status_q == ST_MERGED))
		else $error("merge count moved without a merge");

	a_merge_below_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_q == ST_MERGED) |-> ($past(total_q) < $past(merge_lim)))
		else $error("merge made at or past the merge limit");

	a_fix_not_root: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIX) |-> (cur_q != root_q))
		else $error("path compression relinks the root");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == S_IDLE || $past(state_q) == S_IDLE))
		else $error("result strobe while the walk is still running");

endmodule

[rtl/union_find_cluster_merge.sv]
// Disjoint-set merge engine: each start transfers one edge (node_a, node_b, edge_weight), and
// exactly one result follows on done for a single cycle; the receiver cannot stall it, so it
// must take status, new_root, merges_done and target_reached in that cycle. After reset the
// block stays busy while it initializes the parent-link table. An out-of-range edge gives its
// result in the next cycle without raising busy. Otherwise each endpoint is walked to its root
// (find walk), then any links on its path are pointed at the root (compression walk), and a
// merge step follows; an edge arriving after the merge target is reached gets only a read-only
// walk of node_b. The walks are paced by the parent-link memory, which returns one link per
// cycle from its single registered read port. Configuration must be written through cfg_we
// only while idle, by the user; the block itself does not enforce this.
module union_find_cluster_merge #(
	parameter int MAX_VERTICES = ufcm_pkg::DEF_MAX_VERTICES,
	parameter int WEIGHT_BITS = ufcm_pkg::DEF_WEIGHT_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [ufcm_pkg::NODE_W-1:0]    node_a,
	input  logic [ufcm_pkg::NODE_W-1:0]    node_b,
	input  logic [ufcm_pkg::EDGE_W-1:0]    edge_weight,
	input  logic                           cfg_we,
	input  logic [ufcm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ufcm_pkg::CFG_W-1:0]     cfg_data,
	output logic                           done,
	output ufcm_pkg::status_t              status,
	output logic [ufcm_pkg::NODE_W-1:0]    new_root,
	output logic [ufcm_pkg::CNT_W-1:0]     merges_done,
	output logic                           target_reached
);
	import ufcm_pkg::*;

	localparam int IW = $clog2(MAX_VERTICES);

	logic [CNT_W-1:0]       vcount_q;
	logic [CNT_W-1:0]       ctarget_q;
	logic [CNT_W-1:0]       vtx_n;
	logic [CNT_W-1:0]       merge_lim;

	logic [IW-1:0]          rd_addr;
	logic [IW-1:0]          rd_data;
	logic                   pw_en;
	logic [IW-1:0]          pw_addr;
	logic [IW-1:0]          pw_data;
	logic                   ww_en;
	logic [IW-1:0]          ww_addr;
	logic [WEIGHT_BITS-1:0] ww_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= VERTEX_COUNT_RST;
			ctarget_q <= CLUSTER_TARGET_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_VERTEX_COUNT:   vcount_q <= CNT_W'(cfg_data);
				REG_CLUSTER_TARGET: ctarget_q <= CNT_W'(cfg_data);
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		if (32'(vcount_q) < 32'(MAX_VERTICES)) begin
			vtx_n = vcount_q;
		end else begin
			vtx_n = CNT_W'(MAX_VERTICES);
		end
		if (ctarget_q <= vtx_n) begin
			merge_lim = vtx_n - ctarget_q;
		end else begin
			merge_lim = '0;
		end
	end

	ufcm_mem #(
		.MAX_VERTICES(MAX_VERTICES),
		.WEIGHT_BITS(WEIGHT_BITS)
	) u_mem (
		.clk(clk),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.pw_en(pw_en),
		.pw_addr(pw_addr),
		.pw_data(pw_data),
		.ww_en(ww_en),
		.ww_addr(ww_addr),
		.ww_data(ww_data)
	);

	ufcm_seq #(
		.MAX_VERTICES(MAX_VERTICES),
		.WEIGHT_BITS(WEIGHT_BITS)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.node_a(node_a),
		.node_b(node_b),
		.edge_weight(edge_weight),
		.vtx_n(vtx_n),
		.merge_lim(merge_lim),
		.done(done),
		.status(status),
		.new_root(new_root),
		.merges_done(merges_done),
		.target_reached(target_reached),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.pw_en(pw_en),
		.pw_addr(pw_addr),
		.pw_data(pw_data),
		.ww_en(ww_en),
		.ww_addr(ww_addr),
		.ww_data(ww_data)
	);

endmodule

[tb/sv/tb_union_find_cluster_merge.sv]
module tb_union_find_cluster_merge;
	timeunit 1ns;
	timeprecision 1ps;

	import ufcm_pkg::*;

	localparam int CYCLE_LIMIT = 20_000_000;

	typedef struct {
		status_t           verdict;
		logic [NODE_W-1:0] root;
		logic [CNT_W-1:0]  merges;
		logic              reached;
	} edge_outcome_t;

	class cluster_ledger;
		logic [NODE_W-1:0] parent_of [DEF_MAX_VERTICES];
		logic [EDGE_W-1:0] weight_at [DEF_MAX_VERTICES];
		bit                is_root [DEF_MAX_VERTICES];
		logic [CNT_W-1:0]  merge_total;
		logic [CFG_W-1:0]  vertex_count;
		logic [CFG_W-1:0]  cluster_target;
		edge_outcome_t     outcomes [$];
		int                failures;
		int                tally [4];

		function new();
			for (int i = 0; i < DEF_MAX_VERTICES; i++) begin
				parent_of[i] = NODE_W'(i);
				weight_at[i] = '0;
				is_root[i] = 1'b1;
			end
			merge_total = '0;
			vertex_count = VERTEX_COUNT_RST;
			cluster_target = CLUSTER_TARGET_RST;
			failures = 0;
			foreach (tally[s]) tally[s] = 0;
		endfunction

		function int span();
			return (vertex_count < DEF_MAX_VERTICES) ? int'(vertex_count) : DEF_MAX_VERTICES;
		endfunction

		function int merge_cap();
			int n;
			n = span();
			return (int'(cluster_target) <= n) ? n - int'(cluster_target) : 0;
		endfunction

		function int climb(int v);
			for (int hops = 0; hops < DEF_MAX_VERTICES && int'(parent_of[v]) != v; hops++)
				v = int'(parent_of[v]);
			return v;
		endfunction

		function int flatten(int v);
			int top;
			int nxt;
			top = climb(v);
			while (v != top) begin
				nxt = int'(parent_of[v]);
				parent_of[v] = NODE_W'(top);
				v = nxt;
			end
			return top;
		endfunction

		function void take_edge(logic [NODE_W-1:0] a, logic [NODE_W-1:0] b,
				logic [EDGE_W-1:0] w);
			edge_outcome_t o;
			int n;
			int cap;
			int ra;
			int rb;
			n = span();
			cap = merge_cap();
			o.root = '0;
			if (int'(a) >= n || int'(b) >= n) begin
				o.verdict = ST_RANGE;
			end else if (int'(merge_total) >= cap) begin
				o.verdict = ST_IGNORED;
				o.root = NODE_W'(climb(int'(b)));
			end else begin
				ra = flatten(int'(a));
				rb = flatten(int'(b));
				if (ra == rb) begin
					o.verdict = ST_SAME;
				end else begin
					parent_of[ra] = NODE_W'(rb);
					weight_at[rb] = w;
					is_root[ra] = 1'b0;
					merge_total = merge_total + 1'b1;
					o.verdict = ST_MERGED;
				end
				o.root = NODE_W'(rb);
			end
			o.merges = merge_total;
			o.reached = (int'(merge_total) >= cap);
			outcomes.insert(outcomes.size(), o);
		endfunction

		function void check_result(status_t s, logic [NODE_W-1:0] r, logic [CNT_W-1:0] m,
				logic t);
			edge_outcome_t o;
			if (outcomes.size() == 0) begin
				$error("result with no edge outstanding: status %0d new_root %0d", s, r);
				failures++;
			end else begin
				o = outcomes.pop_front();
				if (!$isunknown(s))
					tally[s]++;
				if (s !== o.verdict) begin
					$error("status expected %0d got %0d", o.verdict, s);
					failures++;
				end
				if (r !== o.root) begin
					$error("new_root expected %0d got %0d", o.root, r);
					failures++;
				end
				if (m !== o.merges) begin
					$error("merges_done expected %0d got %0d", o.merges, m);
					failures++;
				end
				if (t !== o.reached) begin
					$error("target_reached expected %0d got %0d", o.reached, t);
					failures++;
				end
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	logic [NODE_W-1:0]    node_a = '0;
	logic [NODE_W-1:0]    node_b = '0;
	logic [EDGE_W-1:0]    edge_weight = '0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 done;
	status_t              status;
	logic [NODE_W-1:0]    new_root;
	logic [CNT_W-1:0]     merges_done;
	logic                 target_reached;

	cluster_ledger ledger;
	int cycles = 0;
	int settings = 0;
	int edges_sent = 0;
	int chain_end = 0;

	union_find_cluster_merge dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.node_a(node_a),
		.node_b(node_b),
		.edge_weight(edge_weight),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.done(done),
		.status(status),
		.new_root(new_root),
		.merges_done(merges_done),
		.target_reached(target_reached)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_union_find_cluster_merge failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done)
			ledger.check_result(status, new_root, merges_done, target_reached);
	end

	task automatic send_edge(input logic [NODE_W-1:0] a, input logic [NODE_W-1:0] b,
			input logic [EDGE_W-1:0] w, input int idle_pct);
		int gap;
		gap = (int'($urandom_range(99)) < idle_pct) ? int'($urandom_range(1, 4)) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		node_a <= a;
		node_b <= b;
		edge_weight <= w;
		do @(posedge clk); while (busy);
		ledger.take_edge(a, b, w);
		edges_sent++;
	endtask

	// drop start and hold until every transfer has its result
	task automatic settle();
		start <= 1'b0;
		while (ledger.outcomes.size() != 0) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic set_clustering(input logic [CFG_W-1:0] vc, input logic [CFG_W-1:0] ct);
		cfg_we <= 1'b1;
		cfg_index <= REG_VERTEX_COUNT;
		cfg_data <= vc;
		@(posedge clk);
		cfg_index <= REG_CLUSTER_TARGET;
		cfg_data <= ct;
		@(posedge clk);
		cfg_we <= 1'b0;
		ledger.vertex_count = vc;
		ledger.cluster_target = ct;
		settings++;
	endtask

	task automatic run_edges(input int count, input int idle_pct, input bit pause_midway);
		int n;
		int pick;
		logic [NODE_W-1:0] a;
		logic [NODE_W-1:0] b;
		logic [EDGE_W-1:0] w;
		n = ledger.span();
		if (chain_end >= n)
			chain_end = 0;
		for (int k = 0; k < count; k++) begin
			pick = int'($urandom_range(99));
			w = EDGE_W'($urandom);
			if (pick < 40) begin
				// grow a long parent chain so later walks run deep
				a = NODE_W'(chain_end);
				chain_end = (chain_end + 1) % n;
				b = NODE_W'(chain_end);
			end else if (pick < 80) begin
				a = NODE_W'($urandom_range(n - 1));
				b = NODE_W'($urandom_range(n - 1));
			end else if (pick < 85) begin
				a = NODE_W'($urandom_range(n - 1));
				b = a;
			end else begin
				a = NODE_W'($urandom);
				b = NODE_W'($urandom);
			end
			if (pick % 20 == 7)
				w = pick[0] ? '1 : '0;
			if (pause_midway && k == count / 2)
				settle();
			send_edge(a, b, w, idle_pct);
		end
	endtask

	initial begin
		ledger = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		settle();

		set_clustering(11'd8, 11'd2);
		send_edge(10'd0, 10'd0, 16'h0000, 0);
		send_edge(10'd0, 10'd1, 16'hFFFF, 0);
		send_edge(10'd1, 10'd0, 16'h1234, 0);
		send_edge(10'd2, 10'd3, 16'h0001, 0);
		send_edge(10'd1, 10'd3, 16'h8000, 0);
		send_edge(10'd4, 10'd5, 16'h7FFF, 0);
		send_edge(10'd6, 10'd7, 16'hA5A5, 0);
		send_edge(10'd5, 10'd7, 16'h5A5A, 0);
		send_edge(10'd0, 10'd7, 16'hFFFF, 0);
		send_edge(10'd8, 10'd0, 16'h0000, 0);
		send_edge(10'd0, 10'd8, 16'h0000, 0);
		send_edge(10'd1023, 10'd1023, 16'hFFFF, 0);
		settle();
		set_clustering(11'd2047, 11'd1024);
		send_edge(10'd1023, 10'd0, 16'hFFFF, 0);
		send_edge(10'd0, 10'd1023, 16'h0000, 0);
		settle();
		set_clustering(11'd0, 11'd5);
		send_edge(10'd0, 10'd0, 16'h0F0F, 0);
		settle();
		set_clustering(11'd1, 11'd1);
		send_edge(10'd0, 10'd0, 16'hF0F0, 0);
		send_edge(10'd0, 10'd1, 16'h0000, 0);
		settle();

		set_clustering(11'd1024, 11'd512);
		run_edges(300, 0, 1'b0);
		settle();
		set_clustering(11'd2047, 11'd100);
		run_edges(300, 53, 1'b1);
		settle();
		set_clustering(11'd700, 11'd1);
		run_edges(200, 14, 1'b0);
		settle();
		set_clustering(11'd1024, 11'd0);
		run_edges(250, 53, 1'b1);
		settle();
		repeat (24) @(posedge clk);

		$display("%0d edges over %0d cluster settings: %0d merged, %0d same cluster,",
			edges_sent, settings, ledger.tally[ST_MERGED], ledger.tally[ST_SAME]);
		$display("%0d ignored at target, %0d out of range, final merge count %0d",
			ledger.tally[ST_IGNORED], ledger.tally[ST_RANGE], ledger.merge_total);
		if (ledger.failures == 0)
			$display("tb_union_find_cluster_merge passed");
		else
			$display("tb_union_find_cluster_merge failed");
		$finish;
	end

endmodule
